// File: rtl/tpr_pkg.sv
// Shared types, register indexes and the control program for the throttle ratio block.
`timescale 1ns / 1ps

package tpr_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_VALID_LOW    = 3'd0;
  localparam logic [2:0] REG_VALID_HIGH   = 3'd1;
  localparam logic [2:0] REG_DEADBAND     = 3'd2;
  localparam logic [2:0] REG_CENTER_WIDTH = 3'd3;
  localparam logic [2:0] REG_ARM_WIDTH    = 3'd4;
  localparam logic [2:0] REG_FLOOR_RATIO  = 3'd5;
  localparam logic [2:0] REG_FULL_RATIO   = 3'd6;
  localparam logic [2:0] REG_SMOOTHING    = 3'd7;

  typedef struct packed {
    logic [15:0] valid_low;
    logic [15:0] valid_high;
    logic [15:0] deadband;
    logic [15:0] center_width;
    logic [14:0] arm_width;
    logic [15:0] floor_ratio;
    logic [15:0] full_ratio;
    logic [15:0] smoothing;
  } cfg_t;

  typedef logic [3:0] step_t;

  localparam step_t STEP_FETCH    = 4'd0;
  localparam step_t STEP_WINDOW   = 4'd1;
  localparam step_t STEP_SPAN     = 4'd2;
  localparam step_t STEP_DIV      = 4'd3;
  localparam step_t STEP_MUL_TGT  = 4'd4;
  localparam step_t STEP_TARGET   = 4'd5;
  localparam step_t STEP_MUL_FILT = 4'd6;
  localparam step_t STEP_FILTER   = 4'd7;
  localparam step_t STEP_EMIT     = 4'd8;
  localparam step_t STEP_RETURN   = 4'd9;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_FETCH,
    OP_WINDOW,
    OP_SPAN,
    OP_DIV,
    OP_MUL_TGT,
    OP_TARGET,
    OP_MUL_FILT,
    OP_FILTER,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_IN,
    C_FAIL,
    C_SAT,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic fail;
    logic sat;
    logic div_last;
    logic out_busy;
  } stat_t;

  function automatic ctrl_t rom_word(step_t step);
    ctrl_t w;
    unique case (step)
      STEP_FETCH:    w = '{op: OP_FETCH,    cond: C_NO_IN,    target: STEP_FETCH};
      STEP_WINDOW:   w = '{op: OP_WINDOW,   cond: C_FAIL,     target: STEP_EMIT};
      STEP_SPAN:     w = '{op: OP_SPAN,     cond: C_SAT,      target: STEP_MUL_TGT};
      STEP_DIV:      w = '{op: OP_DIV,      cond: C_DIV_MORE, target: STEP_DIV};
      STEP_MUL_TGT:  w = '{op: OP_MUL_TGT,  cond: C_NEXT,     target: STEP_FETCH};
      STEP_TARGET:   w = '{op: OP_TARGET,   cond: C_NEXT,     target: STEP_FETCH};
      STEP_MUL_FILT: w = '{op: OP_MUL_FILT, cond: C_NEXT,     target: STEP_FETCH};
      STEP_FILTER:   w = '{op: OP_FILTER,   cond: C_NEXT,     target: STEP_FETCH};
      STEP_EMIT:     w = '{op: OP_EMIT,     cond: C_OUT_BUSY, target: STEP_EMIT};
      STEP_RETURN:   w = '{op: OP_NOP,      cond: C_ALWAYS,   target: STEP_FETCH};
      default:       w = '{op: OP_NOP,      cond: C_ALWAYS,   target: STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/tpr_cfg.sv
// Configuration register file written through a plain index/data port.
`timescale 1ns / 1ps

module tpr_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output tpr_pkg::cfg_t cfg
);
  import tpr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.valid_low    <= 16'd800;
      cfg.valid_high   <= 16'd2200;
      cfg.deadband     <= 16'd4;
      cfg.center_width <= 16'd1500;
      cfg.arm_width    <= 15'd500;
      cfg.floor_ratio  <= 16'd0;
      cfg.full_ratio   <= 16'd65535;
      cfg.smoothing    <= 16'd6554;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VALID_LOW:    cfg.valid_low    <= cfg_data;
        REG_VALID_HIGH:   cfg.valid_high   <= cfg_data;
        REG_DEADBAND:     cfg.deadband     <= cfg_data;
        REG_CENTER_WIDTH: cfg.center_width <= cfg_data;
        REG_ARM_WIDTH:    cfg.arm_width    <= cfg_data[14:0];
        REG_FLOOR_RATIO:  cfg.floor_ratio  <= cfg_data;
        REG_FULL_RATIO:   cfg.full_ratio   <= cfg_data;
        REG_SMOOTHING:    cfg.smoothing    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/tpr_seq.sv
// Microcode sequencer: step counter, program lookup and conditional jumps.
`timescale 1ns / 1ps

module tpr_seq (
  input  logic           clk,
  input  logic           rst,
  input  tpr_pkg::stat_t stat,
  output tpr_pkg::ctrl_t ctrl,
  output tpr_pkg::step_t pc
);
  import tpr_pkg::*;

  step_t pc_next;
  logic  take;

  assign ctrl = rom_word(pc);

  always_comb begin
    unique case (ctrl.cond)
      C_NEXT:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = !stat.in_fire;
      C_FAIL:     take = stat.fail;
      C_SAT:      take = stat.sat;
      C_DIV_MORE: take = !stat.div_last;
      C_OUT_BUSY: take = stat.out_busy;
      default:    take = 1'b1;
    endcase
    pc_next = take ? ctrl.target : step_t'(pc + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: rtl/tpr_dp.sv
// Datapath: window check, deadband hold, serial divider, shared multiplier, filter, output beat.
`timescale 1ns / 1ps

module tpr_dp #(
  parameter int RATIO_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  tpr_pkg::cfg_t  cfg,
  input  tpr_pkg::ctrl_t ctrl,
  output tpr_pkg::stat_t stat,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [15:0]    pulse_width,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    ratio,
  output logic           failsafe
);
  import tpr_pkg::*;

  localparam int CW  = $clog2(RATIO_BITS);
  localparam int AW  = (RATIO_BITS + 2 > 17) ? RATIO_BITS + 2 : 17;
  localparam int PW  = AW + 17;
  localparam logic [RATIO_BITS:0] ONE = {1'b1, {RATIO_BITS{1'b0}}};

  logic [15:0]           pw;
  logic [15:0]           held;
  logic [15:0]           filt;
  logic [15:0]           rem;
  logic [RATIO_BITS:0]   quo;
  logic [CW-1:0]         cnt;
  logic signed [PW-1:0]  prod;
  logic [15:0]           tgt;
  logic                  fs;

  logic [15:0]           diff;
  logic [15:0]           low;
  logic [15:0]           k;
  logic [15:0]           travel;
  logic [15:0]           span;
  logic [16:0]           r2;
  logic                  qbit;
  logic signed [AW-1:0]  mul_a;
  logic signed [16:0]    mul_b;
  logic signed [PW-1:0]  shr_t;
  logic signed [PW-1:0]  shr_f;

  assign in_ready = (ctrl.op == OP_FETCH) && !rst;

  always_comb begin
    diff   = (pw > held) ? 16'(pw - held) : 16'(held - pw);
    low    = 16'(cfg.center_width - {1'b0, cfg.arm_width});
    k      = (held < low) ? low : held;
    travel = 16'(k - low);
    span   = {cfg.arm_width, 1'b0};
    r2     = {rem, 1'b0};
    qbit   = (r2 >= {1'b0, span});
    // one multiplier serves both products
    if (ctrl.op == OP_MUL_TGT) begin
      mul_a = $signed({{(AW - RATIO_BITS - 1){1'b0}}, quo});
      mul_b = $signed({1'b0, cfg.full_ratio}) - $signed({1'b0, cfg.floor_ratio});
    end else begin
      mul_a = $signed({{(AW - 16){1'b0}}, cfg.smoothing});
      mul_b = $signed({1'b0, tgt}) - $signed({1'b0, filt});
    end
    shr_t = prod >>> RATIO_BITS;
    shr_f = prod >>> 16;
  end

  always_comb begin
    stat.in_fire  = in_valid && in_ready;
    stat.fail     = (pw < cfg.valid_low) || (pw > cfg.valid_high);
    stat.sat      = (cfg.arm_width == 15'd0) || (travel >= span);
    stat.div_last = (cnt == CW'(RATIO_BITS - 1));
    stat.out_busy = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 16'd0;
      filt      <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.op == OP_EMIT && !stat.out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (ctrl.op)
        OP_WINDOW: begin
          if (!stat.fail && (held == 16'd0 || diff > cfg.deadband)) begin
            held <= pw;
          end
        end
        OP_FILTER: filt <= 16'(filt + shr_f[15:0]);
        default: ;
      endcase
    end
  end

  // payload and working registers, no reset needed
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_FETCH: begin
        if (stat.in_fire) begin
          pw <= pulse_width;
        end
      end
      OP_WINDOW: fs <= stat.fail;
      OP_SPAN: begin
        rem <= travel;
        quo <= stat.sat ? ONE : '0;
        cnt <= '0;
      end
      OP_DIV: begin
        rem <= qbit ? 16'(r2 - {1'b0, span}) : r2[15:0];
        quo <= {quo[RATIO_BITS-1:0], qbit};
        cnt <= CW'(cnt + 1'b1);
      end
      OP_MUL_TGT, OP_MUL_FILT: prod <= PW'(mul_a) * PW'(mul_b);
      OP_TARGET: tgt <= 16'(cfg.floor_ratio + shr_t[15:0]);
      OP_EMIT: begin
        if (!stat.out_busy) begin
          ratio    <= fs ? cfg.full_ratio : filt;
          failsafe <= fs;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/throttle_pulse_to_ratio_core.sv
// Steps: a failing input goes from the window check straight to emit; a normal one runs span,
// the serial divider (skipped when the travel saturates), target and filter products, then emit.
// One item at a time: a new input is taken only in the fetch step; the bit-serial divider, one
// quotient bit a cycle, sets the pace, with the shared multiplier used in two separate steps.
// Reset (rst, synchronous): configuration registers take their defaults, held width and filter clear.
`timescale 1ns / 1ps

module throttle_pulse_to_ratio_core #(
  parameter int RATIO_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] pulse_width,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] ratio,
  output logic        failsafe,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tpr_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;
  stat_t stat;
  step_t pc;

  tpr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpr_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl),
    .pc   (pc)
  );

  tpr_dp #(
    .RATIO_BITS (RATIO_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .ctrl        (ctrl),
    .stat        (stat),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pulse_width (pulse_width),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ratio       (ratio),
    .failsafe    (failsafe)
  );

  // one item in flight: no second beat straight after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // a fresh result only comes from the emit step
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(pc) == STEP_EMIT))
    else $error("result raised outside the emit step");

  // the sequencer is busy with an item whenever a result is being emitted
  a_emit_not_ready: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_EMIT) |-> !in_ready)
    else $error("input ready during emit");

endmodule
